// File: sv/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and codes for the stitch repeat expander.
// ----------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

    // repeat modes
    localparam logic [1:0] MODE_SINGLE      = 2'd0;
    localparam logic [1:0] MODE_BACK_FORTH  = 2'd1;
    localparam logic [1:0] MODE_BEAN        = 2'd2;
    localparam logic [1:0] MODE_BACKSTITCH  = 2'd3;

    // configuration register indexes
    localparam logic REG_REPEAT_MODE = 1'b0;
    localparam logic REG_PASS_COUNT  = 1'b1;

    // register reset values
    localparam logic [1:0] MODE_RESET = MODE_SINGLE;
    localparam logic [3:0] PASS_RESET = 4'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_REV,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// File: sv/stitch_repeat_expander.sv
// ----------------------------------------------------------------------------
// stitch_repeat_expander
// Expands a stitch path by single pass, back and forth, bean or backstitch.
// ----------------------------------------------------------------------------
// Points enter on the s_ stream, one item per point, s_tlast on the last point
// of a path. Expanded points leave on the m_ stream; m_tlast marks the last
// item caused by one input point, m_tuser carries the end of the expanded path
// and the store overflow flag. The user must write repeat_mode and pass_count
// through the cfg_ port only while the block is idle; the block itself does
// not enforce this. The sequencer takes one input item at a time: it accepts
// the item, works through each candidate point in turn, then releases the
// final item. The reverse leg of back and forth reads the point store one
// entry per cycle while the output does not stall, through its registered
// read port. A result passes through a holding slot before it reaches the
// output register. A finished result waits in the output register while the
// next candidate waits in the holding slot; when the receiver stalls with both
// full, the sequencer pauses unless the candidate is a dropped null move.
// Reset clears the path state and sets repeat_mode to single pass and
// pass_count to three; the point store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module stitch_repeat_expander #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // fields from bit 0: in_x, in_y, zero fill
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic                              s_tlast,

    // fields from bit 0: out_x, out_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   m_tlast,
    // fields from bit 0: sequence_end, store_overflow
    output logic [1:0]                             m_tuser,

    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [3:0]                        cfg_data
);

    localparam int PW = 2 * COORD_BITS;
    localparam int DW = ((PW + 7) / 8) * 8;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // configuration
    logic [1:0] mode_reg;
    logic [3:0] pass_reg;

    // path state
    logic [CW-1:0] cnt_reg,       cnt_next;
    logic          have_prev_reg, have_prev_next;
    logic          ovf_reg,       ovf_next;
    logic [PW-1:0] prev_reg,      prev_next;
    logic [PW-1:0] last_reg,      last_next;

    // current item
    srq_pkg::state_t state_reg, state_next;
    logic [PW-1:0] cur_reg,    cur_next;
    logic [PW-1:0] iprev_reg,  iprev_next;
    logic          end_reg,    end_next;
    logic          iovf_reg,   iovf_next;
    logic          force_reg,  force_next;
    logic          rev_reg,    rev_next;
    logic [3:0]    limit_reg,  limit_next;
    logic [3:0]    k_reg,      k_next;
    logic [AW-1:0] rstart_reg, rstart_next;
    logic [AW-1:0] raddr_reg,  raddr_next;

    // holding slot and output register
    logic          pend_valid_reg, pend_valid_next;
    logic [PW-1:0] pend_reg,       pend_next;
    logic          m_valid_reg,    m_valid_next;
    logic [PW-1:0] out_pt_reg,     out_pt_next;
    logic          out_last_reg,   out_last_next;
    logic          out_seq_reg,    out_seq_next;
    logic          out_ovf_reg,    out_ovf_next;

    // store ports
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    logic [PW-1:0] st_rdata;

    // helpers
    logic [PW-1:0] in_pt;
    logic          room;
    logic [CW-1:0] cnt_after;
    logic [3:0]    bean_passes;
    logic [PW-1:0] cand;
    logic          drop;
    logic          slot_free;
    logic          step;

    srq_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (in_pt),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign in_pt     = s_tdata[PW-1:0];
    assign room      = (cnt_reg < CW'(MAX_POINTS));
    assign cnt_after = room ? cnt_reg + CW'(1) : cnt_reg;
    assign s_tready  = (state_reg == srq_pkg::ST_IDLE);

    assign st_we    = s_tvalid && s_tready && room;
    assign st_waddr = cnt_reg[AW-1:0];

    // odd pass count, three at least
    always_comb
    begin
        bean_passes = pass_reg | 4'd1;
        if (bean_passes < 4'd3)
        begin
            bean_passes = 4'd3;
        end
    end

    // candidate point and null-move check
    always_comb
    begin
        if (state_reg == srq_pkg::ST_REV)
        begin
            cand = st_rdata;
        end
        else if (k_reg[0])
        begin
            cand = iprev_reg;
        end
        else
        begin
            cand = cur_reg;
        end
    end

    assign drop      = !force_reg && (cand == last_reg);
    assign slot_free = !pend_valid_reg || !m_valid_reg || m_tready;
    assign step      = drop || slot_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= srq_pkg::MODE_RESET;
            pass_reg <= srq_pkg::PASS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srq_pkg::REG_REPEAT_MODE: mode_reg <= cfg_data[1:0];
                srq_pkg::REG_PASS_COUNT:  pass_reg <= cfg_data;
                default:                  mode_reg <= mode_reg;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        have_prev_next  = have_prev_reg;
        ovf_next        = ovf_reg;
        prev_next       = prev_reg;
        last_next       = last_reg;
        cur_next        = cur_reg;
        iprev_next      = iprev_reg;
        end_next        = end_reg;
        iovf_next       = iovf_reg;
        force_next      = force_reg;
        rev_next        = rev_reg;
        limit_next      = limit_reg;
        k_next          = k_reg;
        rstart_next     = rstart_reg;
        raddr_next      = raddr_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_pt_next     = out_pt_reg;
        out_last_next   = out_last_reg;
        out_seq_next    = out_seq_reg;
        out_ovf_next    = out_ovf_reg;
        st_re           = 1'b0;
        st_raddr        = raddr_reg;

        case (state_reg)
            srq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // latch the item and update the path state
                    cur_next    = in_pt;
                    iprev_next  = prev_reg;
                    end_next    = s_tlast;
                    iovf_next   = ovf_reg || !room;
                    k_next      = 4'd0;
                    rstart_next = AW'(cnt_after - CW'(2));
                    force_next  = !have_prev_reg || (mode_reg == srq_pkg::MODE_SINGLE)
                                  || (mode_reg == srq_pkg::MODE_BACK_FORTH);
                    rev_next    = have_prev_reg && s_tlast
                                  && (mode_reg == srq_pkg::MODE_BACK_FORTH)
                                  && (cnt_after >= CW'(2));
                    if (!have_prev_reg)
                    begin
                        limit_next = 4'd1;
                    end
                    else
                    begin
                        case (mode_reg)
                            srq_pkg::MODE_BEAN:       limit_next = bean_passes;
                            srq_pkg::MODE_BACKSTITCH: limit_next = s_tlast ? 4'd3 : 4'd2;
                            default:                  limit_next = 4'd1;
                        endcase
                    end
                    if (s_tlast)
                    begin
                        cnt_next       = '0;
                        have_prev_next = 1'b0;
                        ovf_next       = 1'b0;
                        prev_next      = '0;
                    end
                    else
                    begin
                        cnt_next       = cnt_after;
                        have_prev_next = 1'b1;
                        ovf_next       = ovf_reg || !room;
                        prev_next      = in_pt;
                    end
                    state_next = srq_pkg::ST_GEN;
                end
            end

            srq_pkg::ST_GEN,
            srq_pkg::ST_REV:
            begin
                if (step)
                begin
                    // a kept point pushes the held one out
                    if (!drop)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_valid_next  = 1'b1;
                            out_pt_next   = pend_reg;
                            out_last_next = 1'b0;
                            out_seq_next  = 1'b0;
                            out_ovf_next  = iovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = cand;
                        last_next       = cand;
                    end
                    if (state_reg == srq_pkg::ST_GEN)
                    begin
                        if (k_reg == limit_reg - 4'd1)
                        begin
                            force_next = 1'b0;
                            if (rev_reg)
                            begin
                                st_re      = 1'b1;
                                st_raddr   = rstart_reg;
                                raddr_next = rstart_reg;
                                state_next = srq_pkg::ST_REV;
                            end
                            else
                            begin
                                state_next = srq_pkg::ST_FLUSH;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 4'd1;
                        end
                    end
                    else if (raddr_reg == '0)
                    begin
                        state_next = srq_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        // fetch the next older entry
                        st_re      = 1'b1;
                        st_raddr   = raddr_reg - AW'(1);
                        raddr_next = raddr_reg - AW'(1);
                    end
                end
            end

            srq_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = srq_pkg::ST_IDLE;
                    if (end_reg)
                    begin
                        last_next = '0;
                    end
                end
                else if (!m_valid_reg || m_tready)
                begin
                    // final item of this input point
                    m_valid_next    = 1'b1;
                    out_pt_next     = pend_reg;
                    out_last_next   = 1'b1;
                    out_seq_next    = end_reg;
                    out_ovf_next    = iovf_reg;
                    pend_valid_next = 1'b0;
                    state_next      = srq_pkg::ST_IDLE;
                    if (end_reg)
                    begin
                        last_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = srq_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srq_pkg::ST_IDLE;
            cnt_reg        <= '0;
            have_prev_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            prev_reg       <= '0;
            last_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            have_prev_reg  <= have_prev_next;
            ovf_reg        <= ovf_next;
            prev_reg       <= prev_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item and output payload
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        iprev_reg    <= iprev_next;
        end_reg      <= end_next;
        iovf_reg     <= iovf_next;
        force_reg    <= force_next;
        rev_reg      <= rev_next;
        limit_reg    <= limit_next;
        k_reg        <= k_next;
        rstart_reg   <= rstart_next;
        raddr_reg    <= raddr_next;
        pend_reg     <= pend_next;
        out_pt_reg   <= out_pt_next;
        out_last_reg <= out_last_next;
        out_seq_reg  <= out_seq_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'(out_pt_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_seq_reg};

endmodule

`default_nettype wire

// File: sv/srq_ram.sv
// ----------------------------------------------------------------------------
// srq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
